// ===== design/circular_best_fit_slot_allocator_assert.svh =====
// Assertion macros shared by the checkers of the slot allocator.
// A condition that must hold in the same cycle as its trigger.
`ifndef CIRCULAR_BEST_FIT_SLOT_ALLOCATOR_ASSERT_SVH
`define CIRCULAR_BEST_FIT_SLOT_ALLOCATOR_ASSERT_SVH
`define CBFSA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbfsa check failed");
// A condition that must hold in the cycle after its trigger.
`define CBFSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbfsa check failed");
`endif

// ===== design/cbfsa_pkg.sv =====
package cbfsa_pkg;

  // Field widths fixed by the largest ring and the port definitions
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned TICKET_W   = 9;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_RING_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_OCC  = 2'd1;

  localparam logic OP_PARK  = 1'b0;
  localparam logic OP_LEAVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_PARKED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_ROOM   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RELEASED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd4;

  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] start;
    logic [LEN_W-1:0]  len;
  } grant_t;

  // size is the wanted run for a search and the span length for a paint
  typedef struct packed {
    logic              search;
    logic              paint;
    logic              busy;
    logic [LEN_W-1:0]  size;
    logic [SLOT_W-1:0] start;
  } ring_cmd_t;

  typedef struct packed {
    logic              done;
    logic              found;
    logic [SLOT_W-1:0] best_start;
  } ring_sts_t;

endpackage

// ===== design/cbfsa_grant_mem.sv =====
module cbfsa_grant_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  cbfsa_pkg::grant_t wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output cbfsa_pkg::grant_t rdata_o
);
  import cbfsa_pkg::*;

  grant_t mem [DEPTH];
  grant_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/cbfsa_ring.sv =====
module cbfsa_ring #(
  parameter int unsigned RING_SLOTS = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               load_i,
  input  logic [RING_SLOTS-1:0]              load_map_i,
  input  logic [$clog2(RING_SLOTS+1)-1:0]    n_i,
  input  cbfsa_pkg::ring_cmd_t               cmd_i,
  output cbfsa_pkg::ring_sts_t               sts_o
);
  import cbfsa_pkg::*;

  localparam int unsigned SW = $clog2(RING_SLOTS);
  localparam int unsigned LW = $clog2(RING_SLOTS + 1);

  typedef enum logic [1:0] {R_IDLE, R_SCAN, R_PAINT} rstate_e;

  rstate_e               state_q, state_d;
  logic [RING_SLOTS-1:0] map_q, map_d, ring_mask;
  logic [SW-1:0]         idx_q, idx_d, idx_nxt;
  logic                  wrap_q, wrap_d;
  logic                  seen_busy_q, seen_busy_d;
  logic [SW-1:0]         run_start_q, run_start_d;
  logic [LW-1:0]         run_len_q, run_len_d;
  logic                  found_q, found_d;
  logic [SW-1:0]         best_start_q, best_start_d;
  logic [LW-1:0]         best_len_q, best_len_d;
  logic [LEN_W-1:0]      size_q, size_d;
  logic                  paint_busy_q, paint_busy_d;
  logic                  done_q, done_d;
  logic                  cur_busy, at_last, better;

  always_comb begin
    for (int i = 0; i < RING_SLOTS; i++) begin
      ring_mask[i] = (LW'(i) < n_i);
    end
  end

  assign cur_busy = map_q[idx_q];
  assign at_last  = (LW'(idx_q) == (n_i - LW'(1)));
  assign idx_nxt  = at_last ? '0 : idx_q + 1'b1;

  // shorter run wins, equal length goes to the lower start
  assign better = (LEN_W'(run_len_q) >= size_q) &&
                  (!found_q || (run_len_q < best_len_q) ||
                   ((run_len_q == best_len_q) && (run_start_q < best_start_q)));

  always_comb begin
    state_d      = state_q;
    map_d        = map_q;
    idx_d        = idx_q;
    wrap_d       = wrap_q;
    seen_busy_d  = seen_busy_q;
    run_start_d  = run_start_q;
    run_len_d    = run_len_q;
    found_d      = found_q;
    best_start_d = best_start_q;
    best_len_d   = best_len_q;
    size_d       = size_q;
    paint_busy_d = paint_busy_q;
    done_d       = 1'b0;
    if (load_i) begin
      map_d   = load_map_i & ring_mask;
      state_d = R_IDLE;
    end else begin
      case (state_q)
        R_IDLE: begin
          if (cmd_i.search) begin
            size_d = cmd_i.size;
            if (map_q == '0) begin
              // whole ring free: one run from the first slot
              found_d      = (cmd_i.size <= LEN_W'(n_i));
              best_start_d = '0;
              done_d       = 1'b1;
            end else begin
              idx_d       = '0;
              wrap_d      = 1'b0;
              seen_busy_d = 1'b0;
              run_len_d   = '0;
              found_d     = 1'b0;
              state_d     = R_SCAN;
            end
          end else if (cmd_i.paint) begin
            idx_d        = cmd_i.start[SW-1:0];
            size_d       = cmd_i.size;
            paint_busy_d = cmd_i.busy;
            state_d      = R_PAINT;
          end
        end
        R_SCAN: begin
          if (cur_busy) begin
            if (seen_busy_q && (run_len_q != '0) && better) begin
              found_d      = 1'b1;
              best_start_d = run_start_q;
              best_len_d   = run_len_q;
            end
            run_len_d   = '0;
            seen_busy_d = 1'b1;
            // first occupied slot of the second lap closes the wrapping run
            if (wrap_q) begin
              done_d  = 1'b1;
              state_d = R_IDLE;
            end
          end else if (seen_busy_q) begin
            if (run_len_q == '0) begin
              run_start_d = idx_q;
            end
            run_len_d = run_len_q + 1'b1;
          end
          idx_d = idx_nxt;
          if (at_last) begin
            wrap_d = 1'b1;
          end
        end
        R_PAINT: begin
          map_d[idx_q] = paint_busy_q;
          idx_d        = idx_nxt;
          size_d       = size_q - 1'b1;
          if (size_q == LEN_W'(1)) begin
            done_d  = 1'b1;
            state_d = R_IDLE;
          end
        end
        default: begin
          state_d = R_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= R_IDLE;
      map_q        <= '0;
      idx_q        <= '0;
      wrap_q       <= 1'b0;
      seen_busy_q  <= 1'b0;
      run_start_q  <= '0;
      run_len_q    <= '0;
      found_q      <= 1'b0;
      best_start_q <= '0;
      best_len_q   <= '0;
      size_q       <= '0;
      paint_busy_q <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      map_q        <= map_d;
      idx_q        <= idx_d;
      wrap_q       <= wrap_d;
      seen_busy_q  <= seen_busy_d;
      run_start_q  <= run_start_d;
      run_len_q    <= run_len_d;
      found_q      <= found_d;
      best_start_q <= best_start_d;
      best_len_q   <= best_len_d;
      size_q       <= size_d;
      paint_busy_q <= paint_busy_d;
      done_q       <= done_d;
    end
  end

  assign sts_o.done       = done_q;
  assign sts_o.found      = found_q;
  assign sts_o.best_start = SLOT_W'(best_start_q);

endmodule

// ===== design/circular_best_fit_slot_allocator.sv =====
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+--------------------------------------
// in       | input     | in_valid_i / in_stall_o   | op_i, park_size_i, leave_ticket_i
// out      | output    | out_valid_o / out_stall_i | status_o, ticket_o, first_slot_o,
//          |           |                           | last_slot_o, wraps_o
// cfg      | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One transaction at a time: a park scans the ring for the best run, then paints its k slots
// busy (k the size); the scan is skipped on an empty ring and the paint when nothing fits.
// A release reads its grant and paints the span free; a leave of a dead ticket only reads the
// grant, other refusals go straight to the result. The slot walker takes one slot a cycle.
// Reset (rst_ni low, asynchronous) empties the 64-slot ring and clears the ticket count; a
// configuration write reloads the map. A stalled result waits in the output register.
module circular_best_fit_slot_allocator #(
  parameter int unsigned RING_SLOTS   = 64,
  parameter int unsigned MAX_REQUESTS = 256
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   op_i,
  input  logic [cbfsa_pkg::LEN_W-1:0]            park_size_i,
  input  logic [cbfsa_pkg::TICKET_W-1:0]         leave_ticket_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [cbfsa_pkg::STATUS_W-1:0]         status_o,
  output logic [cbfsa_pkg::TICKET_W-1:0]         ticket_o,
  output logic [cbfsa_pkg::LEN_W-1:0]            first_slot_o,
  output logic [cbfsa_pkg::LEN_W-1:0]            last_slot_o,
  output logic                                   wraps_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [cbfsa_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [cbfsa_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import cbfsa_pkg::*;

  localparam int unsigned LW = $clog2(RING_SLOTS + 1);
  localparam int unsigned CW = $clog2(MAX_REQUESTS + 1);
  localparam int unsigned AW = $clog2(MAX_REQUESTS);
  localparam int unsigned XW = (CW > TICKET_W) ? CW : TICKET_W;

  typedef enum logic [2:0] {S_IDLE, S_SEARCH, S_READ, S_PAINT, S_DONE} state_e;

  state_e                 state_q, state_d;
  logic [LEN_W-1:0]       ring_size_q, ring_size_d;
  logic [RING_SLOTS-1:0]  init_occ_q, init_occ_d;
  logic                   reload_q, reload_d;
  logic [CW-1:0]          count_q, count_d;
  logic [LEN_W-1:0]       k_q, k_d;
  logic [AW-1:0]          me_addr_q, me_addr_d;
  logic [AW-1:0]          taddr_q, taddr_d;
  logic [STATUS_W-1:0]    res_status_q, res_status_d;
  logic [TICKET_W-1:0]    res_ticket_q, res_ticket_d;
  logic [LEN_W-1:0]       res_first_q, res_first_d;
  logic [LEN_W-1:0]       res_last_q, res_last_d;
  logic                   res_wraps_q, res_wraps_d;
  logic                   out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]    out_status_q, out_status_d;
  logic [TICKET_W-1:0]    out_ticket_q, out_ticket_d;
  logic [LEN_W-1:0]       out_first_q, out_first_d;
  logic [LEN_W-1:0]       out_last_q, out_last_d;
  logic                   out_wraps_q, out_wraps_d;

  logic                   in_acc, cfg_we;
  logic [LEN_W-1:0]       n_full;
  logic [XW-1:0]          t_x, me_x, t_m1;
  logic [AW-1:0]          t_addr;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  grant_t                 mem_wdata, mem_rdata;
  ring_cmd_t              ring_cmd;
  ring_sts_t              ring_sts;
  logic [SLOT_W-1:0]      span_start;
  logic [LEN_W-1:0]       span_len;
  logic [LEN_W:0]         span_end, span_last_idx, n_ext;
  logic [LEN_W-1:0]       span_first, span_last;
  logic                   span_wraps;

  // Clamp the ring size register into 1..RING_SLOTS
  always_comb begin
    if (ring_size_q == '0) begin
      n_full = LEN_W'(1);
    end else if (ring_size_q > LEN_W'(RING_SLOTS)) begin
      n_full = LEN_W'(RING_SLOTS);
    end else begin
      n_full = ring_size_q;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE) || reload_q;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Ticket arithmetic in a width that holds both the port field and the count
  assign t_x    = XW'(leave_ticket_i);
  assign me_x   = XW'(count_q) + XW'(1);
  assign t_m1   = t_x - XW'(1);
  assign t_addr = t_m1[AW-1:0];

  // Span reporting: 1-based first and last slot, wrap past the end of the ring
  assign span_start    = (state_q == S_READ) ? mem_rdata.start : ring_sts.best_start;
  assign span_len      = (state_q == S_READ) ? mem_rdata.len : k_q;
  assign n_ext         = {1'b0, n_full};
  assign span_end      = (LEN_W + 1)'(span_start) + {1'b0, span_len} - (LEN_W + 1)'(1);
  assign span_wraps    = (span_end >= n_ext);
  assign span_last_idx = span_wraps ? (span_end - n_ext) : span_end;
  assign span_first    = LEN_W'(span_start) + LEN_W'(1);
  assign span_last     = span_last_idx[LEN_W-1:0] + LEN_W'(1);

  always_comb begin
    state_d      = state_q;
    ring_size_d  = ring_size_q;
    init_occ_d   = init_occ_q;
    reload_d     = 1'b0;
    count_d      = count_q;
    k_d          = k_q;
    me_addr_d    = me_addr_q;
    taddr_d      = taddr_q;
    res_status_d = res_status_q;
    res_ticket_d = res_ticket_q;
    res_first_d  = res_first_q;
    res_last_d   = res_last_q;
    res_wraps_d  = res_wraps_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_ticket_d = out_ticket_q;
    out_first_d  = out_first_q;
    out_last_d   = out_last_q;
    out_wraps_d  = out_wraps_q;
    mem_we       = 1'b0;
    mem_waddr    = me_addr_q;
    mem_wdata    = '0;
    ring_cmd     = '0;

    // Writing either register reloads the map and restarts the ticket numbers
    if (cfg_we) begin
      case (cfg_index_i)
        REG_RING_SIZE: begin
          ring_size_d = cfg_data_i[LEN_W-1:0];
          reload_d    = 1'b1;
          count_d     = '0;
        end
        REG_INIT_OCC: begin
          init_occ_d = cfg_data_i[RING_SLOTS-1:0];
          reload_d   = 1'b1;
          count_d    = '0;
        end
        default: begin
          reload_d = 1'b0;
        end
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_first_d = '0;
          res_last_d  = '0;
          res_wraps_d = 1'b0;
          if (count_q >= CW'(MAX_REQUESTS)) begin
            res_status_d = ST_EXHAUSTED;
            res_ticket_d = '0;
            state_d      = S_DONE;
          end else begin
            // Take the next ticket and mark its grant entry empty
            count_d      = count_q + 1'b1;
            res_ticket_d = me_x[TICKET_W-1:0];
            me_addr_d    = count_q[AW-1:0];
            mem_we       = 1'b1;
            mem_waddr    = count_q[AW-1:0];
            if (op_i == OP_PARK) begin
              k_d = park_size_i;
              if (park_size_i == '0) begin
                res_status_d = ST_NO_ROOM;
                state_d      = S_DONE;
              end else begin
                ring_cmd.search = 1'b1;
                ring_cmd.size   = park_size_i;
                state_d         = S_SEARCH;
              end
            end else begin
              if ((t_x == '0) || (t_x >= me_x)) begin
                res_status_d = ST_IGNORED;
                state_d      = S_DONE;
              end else begin
                taddr_d = t_addr;
                state_d = S_READ;
              end
            end
          end
        end
      end
      S_SEARCH: begin
        if (ring_sts.done) begin
          if (ring_sts.found) begin
            mem_we          = 1'b1;
            mem_waddr       = me_addr_q;
            mem_wdata.valid = 1'b1;
            mem_wdata.start = ring_sts.best_start;
            mem_wdata.len   = k_q;
            ring_cmd.paint  = 1'b1;
            ring_cmd.busy   = 1'b1;
            ring_cmd.start  = ring_sts.best_start;
            ring_cmd.size   = k_q;
            res_status_d    = ST_PARKED;
            res_first_d     = span_first;
            res_last_d      = span_last;
            res_wraps_d     = span_wraps;
            state_d         = S_PAINT;
          end else begin
            res_status_d = ST_NO_ROOM;
            state_d      = S_DONE;
          end
        end
      end
      S_READ: begin
        if (!mem_rdata.valid) begin
          res_status_d = ST_IGNORED;
          state_d      = S_DONE;
        end else begin
          // Drop the grant and free its span
          mem_we         = 1'b1;
          mem_waddr      = taddr_q;
          ring_cmd.paint = 1'b1;
          ring_cmd.busy  = 1'b0;
          ring_cmd.start = mem_rdata.start;
          ring_cmd.size  = mem_rdata.len;
          res_status_d   = ST_RELEASED;
          res_first_d    = span_first;
          res_last_d     = span_last;
          res_wraps_d    = span_wraps;
          state_d        = S_PAINT;
        end
      end
      S_PAINT: begin
        if (ring_sts.done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // Hold the result until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_ticket_d = res_ticket_q;
          out_first_d  = res_first_q;
          out_last_d   = res_last_q;
          out_wraps_d  = res_wraps_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ring_size_q  <= LEN_W'(64);
      init_occ_q   <= '0;
      reload_q     <= 1'b0;
      count_q      <= '0;
      k_q          <= '0;
      me_addr_q    <= '0;
      taddr_q      <= '0;
      res_status_q <= ST_PARKED;
      res_ticket_q <= '0;
      res_first_q  <= '0;
      res_last_q   <= '0;
      res_wraps_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_PARKED;
      out_ticket_q <= '0;
      out_first_q  <= '0;
      out_last_q   <= '0;
      out_wraps_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      ring_size_q  <= ring_size_d;
      init_occ_q   <= init_occ_d;
      reload_q     <= reload_d;
      count_q      <= count_d;
      k_q          <= k_d;
      me_addr_q    <= me_addr_d;
      taddr_q      <= taddr_d;
      res_status_q <= res_status_d;
      res_ticket_q <= res_ticket_d;
      res_first_q  <= res_first_d;
      res_last_q   <= res_last_d;
      res_wraps_q  <= res_wraps_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_ticket_q <= out_ticket_d;
      out_first_q  <= out_first_d;
      out_last_q   <= out_last_d;
      out_wraps_q  <= out_wraps_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign ticket_o     = out_ticket_q;
  assign first_slot_o = out_first_q;
  assign last_slot_o  = out_last_q;
  assign wraps_o      = out_wraps_q;

  cbfsa_grant_mem #(
    .DEPTH (MAX_REQUESTS),
    .AW    (AW)
  ) u_grant_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (t_addr),
    .rdata_o (mem_rdata)
  );

  cbfsa_ring #(
    .RING_SLOTS (RING_SLOTS)
  ) u_ring (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (reload_q),
    .load_map_i (init_occ_q),
    .n_i        (n_full[LW-1:0]),
    .cmd_i      (ring_cmd),
    .sts_o      (ring_sts)
  );

endmodule

// ===== design/cbfsa_checker.sv =====
`include "circular_best_fit_slot_allocator_assert.svh"

module cbfsa_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic [cbfsa_pkg::STATUS_W-1:0]   status_o,
  input logic [cbfsa_pkg::TICKET_W-1:0]   ticket_o,
  input logic [cbfsa_pkg::LEN_W-1:0]      first_slot_o,
  input logic [cbfsa_pkg::LEN_W-1:0]      last_slot_o,
  input logic                             wraps_o
);
  import cbfsa_pkg::*;

  // A stalled result stays offered
  `CBFSA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // Exhausted numbers carry no ticket and no span
  `CBFSA_ASSERT_NOW(a_exhausted_clear, clk_i, rst_ni, out_valid_o && (status_o == ST_EXHAUSTED), (ticket_o == '0) && (first_slot_o == '0) && (last_slot_o == '0) && !wraps_o)

  // Refused parks and ignored leaves report no span
  `CBFSA_ASSERT_NOW(a_refused_clear, clk_i, rst_ni, out_valid_o && ((status_o == ST_NO_ROOM) || (status_o == ST_IGNORED)), (first_slot_o == '0) && (last_slot_o == '0) && !wraps_o)

  // A granted or freed span is non-empty and wraps exactly when it ends before it starts
  `CBFSA_ASSERT_NOW(a_span_shape, clk_i, rst_ni, out_valid_o && ((status_o == ST_PARKED) || (status_o == ST_RELEASED)), (first_slot_o != '0) && (last_slot_o != '0) && (wraps_o == (last_slot_o < first_slot_o)))

endmodule

bind circular_best_fit_slot_allocator cbfsa_checker u_cbfsa_checker (.*);

// ===== tb/circular_best_fit_slot_allocator_tb.sv =====
`timescale 1ns / 1ps

module circular_best_fit_slot_allocator_tb;
  import cbfsa_pkg::*;

  localparam int unsigned RING_MAX    = 64;
  localparam int unsigned MAX_TICKETS = 256;

  // One answer of the allocator, laid out in port order
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TICKET_W-1:0] ticket;
    logic [LEN_W-1:0]    first_slot;
    logic [LEN_W-1:0]    last_slot;
    logic                wraps;
  } slot_answer_t;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic                  op_i           = OP_PARK;
  logic [LEN_W-1:0]      park_size_i    = '0;
  logic [TICKET_W-1:0]   leave_ticket_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic [STATUS_W-1:0]   status_o;
  logic [TICKET_W-1:0]   ticket_o;
  logic [LEN_W-1:0]      first_slot_o;
  logic [LEN_W-1:0]      last_slot_o;
  logic                  wraps_o;
  logic                  cfg_valid_i    = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = REG_RING_SIZE;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;

  // Allocator mirror: registers, occupancy map, ticket counter and grant memory
  logic [LEN_W-1:0]      ring_size_reg;
  logic [CFG_DATA_W-1:0] init_occ_reg;
  logic [RING_MAX-1:0]   occupancy;
  int unsigned           tickets_issued;
  bit                    span_live  [0:MAX_TICKETS];
  int unsigned           span_first [0:MAX_TICKETS];
  int unsigned           span_len   [0:MAX_TICKETS];

  slot_answer_t answers_due[$];
  int unsigned  answers_pending;
  int unsigned  live_tickets[$];
  int unsigned  fault_count;

  // Idle odds in percent, and a long receiver hold-off counted down in cycles
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_left;

  circular_best_fit_slot_allocator #(
    .RING_SLOTS  (RING_MAX),
    .MAX_REQUESTS(MAX_TICKETS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .park_size_i   (park_size_i),
    .leave_ticket_i(leave_ticket_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .ticket_o      (ticket_o),
    .first_slot_o  (first_slot_o),
    .last_slot_o   (last_slot_o),
    .wraps_o       (wraps_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Clamp the ring size register: zero acts as one slot, anything above the ring as the ring
  function automatic int unsigned active_slots();
    if (ring_size_reg == 0) return 1;
    if (ring_size_reg > RING_MAX) return RING_MAX;
    return ring_size_reg;
  endfunction

  // Reload the map from the occupancy register, drop every grant and restart numbering
  function automatic void reload_ring();
    int unsigned n;
    n = active_slots();
    occupancy = init_occ_reg;
    for (int unsigned i = n; i < RING_MAX; i++) occupancy[i] = 1'b0;
    tickets_issued = 0;
    for (int unsigned i = 0; i <= MAX_TICKETS; i++) span_live[i] = 1'b0;
  endfunction

  function automatic void paint_span(input int unsigned first, input int unsigned len,
                                     input bit busy);
    int unsigned n;
    n = active_slots();
    for (int unsigned i = 0; i < len; i++) occupancy[(first + i) % n] = busy;
  endfunction

  // Fill in the 1-based span fields; a span runs past the top of the ring when it wraps
  function automatic slot_answer_t with_span(input slot_answer_t ans, input int unsigned first,
                                             input int unsigned len);
    int unsigned n;
    int unsigned tail;
    n = active_slots();
    tail = first + len - 1;
    ans.first_slot = LEN_W'(first + 1);
    ans.last_slot  = LEN_W'((tail % n) + 1);
    ans.wraps      = (tail >= n);
    return ans;
  endfunction

  // Work out the answer to one accepted request and advance the mirror
  function automatic slot_answer_t park_or_leave(input logic op, input logic [LEN_W-1:0] size,
                                                 input logic [TICKET_W-1:0] tkt);
    slot_answer_t ans;
    int unsigned  n;
    int unsigned  me;
    int unsigned  run;
    int unsigned  best_first;
    int unsigned  best_len;
    bit           found;
    ans = '0;
    n = active_slots();
    if (tickets_issued >= MAX_TICKETS) begin
      ans.status = ST_EXHAUSTED;
      return ans;
    end
    tickets_issued++;
    me = tickets_issued;
    ans.ticket = TICKET_W'(me);
    span_live[me] = 1'b0;

    if (op == OP_PARK) begin
      found      = 1'b0;
      best_first = 0;
      best_len   = 0;
      if (occupancy == '0) begin
        // an empty ring is one run starting at slot 1
        found    = 1'b1;
        best_len = n;
      end else begin
        // consider only slots that open a free run, i.e. follow a busy one
        for (int unsigned s = 0; s < n; s++) begin
          if (occupancy[s] || !occupancy[(s + n - 1) % n]) continue;
          run = 0;
          while (run < n && !occupancy[(s + run) % n]) run++;
          if (run >= size && (!found || run < best_len)) begin
            found      = 1'b1;
            best_first = s;
            best_len   = run;
          end
        end
      end
      if (size == 0 || !found || best_len < size) begin
        ans.status = ST_NO_ROOM;
        return ans;
      end
      paint_span(best_first, size, 1'b1);
      span_live[me]  = 1'b1;
      span_first[me] = best_first;
      span_len[me]   = size;
      ans.status = ST_PARKED;
      return with_span(ans, best_first, size);
    end

    // a leave must name an earlier park that still holds its span
    if (tkt == 0 || tkt >= me || !span_live[tkt]) begin
      ans.status = ST_IGNORED;
      return ans;
    end
    span_live[tkt] = 1'b0;
    paint_span(span_first[tkt], span_len[tkt], 1'b0);
    ans.status = ST_RELEASED;
    return with_span(ans, span_first[tkt], span_len[tkt]);
  endfunction

  task automatic log_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // Offer one request at the falling edge, idle at random first, hold it until taken
  task automatic send_request(input logic op, input logic [LEN_W-1:0] size,
                              input logic [TICKET_W-1:0] tkt);
    slot_answer_t ans;
    @(negedge clk_i);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= op;
    park_size_i    <= size;
    leave_ticket_i <= tkt;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    ans = park_or_leave(op, size, tkt);
    answers_due.push_back(ans);
    answers_pending++;
    if (ans.status == ST_PARKED) live_tickets.push_back(ans.ticket);
    if (ans.status == ST_RELEASED) begin
      for (int i = 0; i < live_tickets.size(); i++) begin
        if (live_tickets[i] == tkt) begin
          live_tickets.delete(i);
          break;
        end
      end
    end
  endtask

  // Drop valid, wait for every answer and then let the block idle
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (answers_pending == 0);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    if (idx == REG_RING_SIZE) ring_size_reg = value[LEN_W-1:0];
    else if (idx == REG_INIT_OCC) init_occ_reg = value;
    reload_ring();
    live_tickets.delete();
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] sparse_occupancy();
    return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
  endfunction

  // Mostly well-formed traffic: small parks and leaves of live tickets; the rest is noise
  // (oversized or zero parks, stray tickets, failed parks, leaves and freed spans)
  task automatic send_random_request();
    int unsigned n;
    int unsigned cap;
    int unsigned pick;
    int unsigned idx;
    n    = active_slots();
    cap  = (n > 3) ? n / 3 : 1;
    pick = $urandom_range(99, 0);
    if (pick < 45) begin
      send_request(OP_PARK, LEN_W'($urandom_range(cap, 1)), TICKET_W'($urandom_range(511, 0)));
    end else if (pick < 75 && live_tickets.size() > 0) begin
      idx = $urandom_range(live_tickets.size() - 1, 0);
      send_request(OP_LEAVE, LEN_W'($urandom_range(127, 0)), TICKET_W'(live_tickets[idx]));
    end else begin
      case (pick % 3)
        0: send_request(OP_PARK, LEN_W'($urandom_range(127, 0)),
                        TICKET_W'($urandom_range(511, 0)));
        1: send_request(OP_LEAVE, LEN_W'($urandom_range(127, 0)),
                        TICKET_W'($urandom_range(511, 0)));
        default: send_request(OP_LEAVE, LEN_W'($urandom_range(127, 0)),
                              TICKET_W'($urandom_range(tickets_issued + 1, 0)));
      endcase
    end
  endtask

  // Reset defaults: full-ring park, refused sizes and every kind of bad leave
  task automatic test_empty_ring_requests();
    send_request(OP_PARK, 64, 0);      // whole ring, slots 1..64
    send_request(OP_PARK, 1, 0);       // ring full
    send_request(OP_LEAVE, 0, 1);
    send_request(OP_LEAVE, 0, 1);      // span already freed
    send_request(OP_PARK, 0, 0);       // zero-size park
    send_request(OP_PARK, 127, 511);   // larger than the ring
    send_request(OP_LEAVE, 127, 0);    // ticket zero
    send_request(OP_LEAVE, 0, 8);      // its own number
    send_request(OP_LEAVE, 0, 511);    // not issued yet
    send_request(OP_LEAVE, 0, 5);      // a refused park
    send_request(OP_LEAVE, 0, 3);      // a leave
    send_request(OP_PARK, 10, 0);
    send_request(OP_PARK, 20, 0);
  endtask

  // Wrapping spans, coalescing, best-fit ties and the ring size extremes
  task automatic test_wrap_and_ties();
    settle();
    write_reg(REG_RING_SIZE, 64);
    write_reg(REG_INIT_OCC, 64'd1 << 10);
    send_request(OP_PARK, 60, 0);      // runs past slot 64 back to slot 7
    send_request(OP_PARK, 3, 0);       // exact fit of the leftover run
    send_request(OP_LEAVE, 0, 1);
    send_request(OP_LEAVE, 0, 2);      // neighbours merge into one run
    send_request(OP_PARK, 63, 0);
    send_request(OP_PARK, 1, 0);
    settle();
    // two equal runs, occupancy bits above the ring ignored
    write_reg(REG_RING_SIZE, 10);
    write_reg(REG_INIT_OCC, (64'd1 << 63) | (64'd1 << 5) | 64'd1);
    send_request(OP_PARK, 3, 0);
    send_request(OP_PARK, 4, 0);
    send_request(OP_PARK, 1, 0);
    settle();
    // a size of zero behaves as a single slot
    write_reg(REG_RING_SIZE, 0);
    write_reg(REG_INIT_OCC, 0);
    send_request(OP_PARK, 1, 0);
    send_request(OP_PARK, 1, 0);
    send_request(OP_LEAVE, 0, 1);
    settle();
    // an oversized ring register behaves as the full ring
    write_reg(REG_RING_SIZE, 127);
    write_reg(REG_INIT_OCC, '1);
    send_request(OP_PARK, 1, 0);
    settle();
    write_reg(REG_INIT_OCC, 0);
    send_request(OP_PARK, 64, 0);
  endtask

  task automatic test_random_traffic(input int unsigned count, input logic [LEN_W-1:0] ring,
                                     input logic [CFG_DATA_W-1:0] occ);
    settle();
    write_reg(REG_RING_SIZE, ring);
    write_reg(REG_INIT_OCC, occ);
    repeat (count) send_random_request();
  endtask

  // Hold the output off for a long stretch while requests keep coming, so that the
  // result register fills and the input stalls
  task automatic test_output_backpressure();
    settle();
    write_reg(REG_RING_SIZE, 16);
    write_reg(REG_INIT_OCC, 0);
    hold_left = 400;
    repeat (10) send_random_request();
  endtask

  // Use up every ticket on a two-slot ring, then check the requests past the last one
  task automatic test_ticket_exhaustion();
    settle();
    write_reg(REG_RING_SIZE, 2);
    write_reg(REG_INIT_OCC, 0);
    repeat (MAX_TICKETS + 6) send_random_request();
  endtask

  // Receiver side: stall at random, or for the whole of a requested hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99, 0) < recv_idle_pct);
    end
  end

  // Compare every answer taken at a rising edge with the oldest one predicted
  always @(posedge clk_i) begin : answer_check
    slot_answer_t seen;
    slot_answer_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      seen = {status_o, ticket_o, first_slot_o, last_slot_o, wraps_o};
      if (answers_pending == 0) begin
        log_fault($sformatf("unexpected answer status %0d ticket %0d", seen.status,
                            seen.ticket));
      end else begin
        want = answers_due.pop_front();
        answers_pending--;
        if (seen.status !== want.status || seen.ticket !== want.ticket ||
            seen.first_slot !== want.first_slot || seen.last_slot !== want.last_slot ||
            seen.wraps !== want.wraps) begin
          log_fault($sformatf({"answer mismatch: expected status %0d ticket %0d ",
                               "slots %0d..%0d wraps %0d, got status %0d ticket %0d ",
                               "slots %0d..%0d wraps %0d"},
                              want.status, want.ticket, want.first_slot, want.last_slot,
                              want.wraps, seen.status, seen.ticket, seen.first_slot,
                              seen.last_slot, seen.wraps));
        end
      end
    end
  end

  initial begin
    ring_size_reg   = 7'd64;
    init_occ_reg    = '0;
    reload_ring();
    answers_pending = 0;
    fault_count     = 0;
    hold_left       = 0;
    send_idle_pct   = 35;
    recv_idle_pct   = 46;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_ring_requests();
    test_wrap_and_ties();
    test_random_traffic(40, 64, sparse_occupancy());

    // swap the idling of the two sides
    send_idle_pct = 46;
    recv_idle_pct = 35;
    test_random_traffic(40, LEN_W'($urandom_range(63, 2)), sparse_occupancy());

    // no idling from here on
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_backpressure();
    test_ticket_exhaustion();
    test_random_traffic(40, LEN_W'($urandom_range(127, 0)), sparse_occupancy());

    settle();
    repeat (300) @(posedge clk_i);
    if (fault_count == 0 && answers_pending == 0) begin
      $display("circular_best_fit_slot_allocator_tb OK");
    end else begin
      $display("circular_best_fit_slot_allocator_tb NOT OK");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run
  initial begin
    #8_000_000;
    $display("circular_best_fit_slot_allocator_tb NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/cbfsa_pkg.sv
design/cbfsa_grant_mem.sv
design/cbfsa_ring.sv
design/circular_best_fit_slot_allocator.sv
design/cbfsa_checker.sv
tb/circular_best_fit_slot_allocator_tb.sv
